@@ rtl/fdve_pkg.sv @@
package fdve_pkg;

    localparam int PC_W   = 4;
    localparam int LOOP_W = 5;
    localparam logic [LOOP_W-1:0] LOOP_LAST = 5'd31;

    localparam logic KIND_INIT    = 1'b0;
    localparam logic KIND_MEASURE = 1'b1;

    localparam logic RTYPE_POS = 1'b0;
    localparam logic RTYPE_VEL = 1'b1;

    localparam logic [31:0] MAX_GAP_RESET = 32'd300000;

    localparam logic [2:0] COND_NONE      = 3'd0;
    localparam logic [2:0] COND_ALWAYS    = 3'd1;
    localparam logic [2:0] COND_NO_ACCEPT = 3'd2;
    localparam logic [2:0] COND_INIT      = 3'd3;
    localparam logic [2:0] COND_OUT_BUSY  = 3'd4;
    localparam logic [2:0] COND_NO_VEL    = 3'd5;
    localparam logic [2:0] COND_LOOP      = 3'd6;

    typedef struct packed {
        logic            take;
        logic            calc;
        logic            emit_pos;
        logic            emit_vel;
        logic            mul;
        logic            sel_pos;
        logic            pre;
        logic            iter;
        logic            save_ang;
        logic [2:0]      cond;
        logic [PC_W-1:0] target;
    } ucode_t;

    typedef struct packed {
        logic accept;
        logic init;
        logic out_busy;
        logic no_vel;
    } seq_status_t;

    function automatic ucode_t ucode_rd(input logic [PC_W-1:0] pc);
        ucode_t w;
        w = '0;
        case (pc)
            4'd0: begin
                w.take = 1'b1; w.cond = COND_NO_ACCEPT; w.target = 4'd0;
            end
            4'd1: begin
                w.calc = 1'b1; w.cond = COND_INIT; w.target = 4'd0;
            end
            4'd2: begin
                w.emit_pos = 1'b1; w.cond = COND_OUT_BUSY; w.target = 4'd2;
            end
            4'd3: begin
                w.cond = COND_NO_VEL; w.target = 4'd0;
            end
            4'd4: begin
                w.mul = 1'b1;
            end
            4'd5: begin
                w.pre = 1'b1;
            end
            4'd6: begin
                w.iter = 1'b1; w.cond = COND_LOOP; w.target = 4'd6;
            end
            4'd7: begin
                w.save_ang = 1'b1;
            end
            4'd8: begin
                w.mul = 1'b1; w.sel_pos = 1'b1;
            end
            4'd9: begin
                w.pre = 1'b1;
            end
            4'd10: begin
                w.iter = 1'b1; w.cond = COND_LOOP; w.target = 4'd10;
            end
            4'd11: begin
                w.emit_vel = 1'b1; w.cond = COND_OUT_BUSY; w.target = 4'd11;
            end
            4'd12: begin
                w.cond = COND_ALWAYS; w.target = 4'd0;
            end
            default: begin
                w.cond = COND_ALWAYS; w.target = 4'd0;
            end
        endcase
        return w;
    endfunction

endpackage

@@ rtl/fdve_seq.sv @@
module fdve_seq
    import fdve_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  seq_status_t st,
    output ucode_t      ctl
);

    logic [PC_W-1:0]   pc_reg, pc_next;
    logic [LOOP_W-1:0] loop_reg, loop_next;
    logic              jump;

    assign ctl = ucode_rd(pc_reg);

    always_comb begin
        case (ctl.cond)
            COND_NONE:      jump = 1'b0;
            COND_ALWAYS:    jump = 1'b1;
            COND_NO_ACCEPT: jump = !st.accept;
            COND_INIT:      jump = st.init;
            COND_OUT_BUSY:  jump = st.out_busy;
            COND_NO_VEL:    jump = st.no_vel;
            COND_LOOP:      jump = (loop_reg != '0);
            default:        jump = 1'b1;
        endcase
        pc_next = jump ? ctl.target : pc_reg + 1'b1;
        if (ctl.pre) begin
            loop_next = LOOP_LAST;
        end else if (ctl.iter) begin
            loop_next = loop_reg - 1'b1;
        end else begin
            loop_next = loop_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg   <= '0;
            loop_reg <= '0;
        end else begin
            pc_reg   <= pc_next;
            loop_reg <= loop_next;
        end
    end

endmodule

@@ rtl/fdve_div.sv @@
module fdve_div
    import fdve_pkg::*;
#(
    parameter int TICKS_PER_SECOND = 1000000
) (
    input  logic               aclk,
    input  ucode_t             ctl,
    input  logic signed [32:0] diff,
    input  logic [31:0]        dt,
    output logic [31:0]        rate
);

    localparam int TW = $clog2(TICKS_PER_SECOND + 1);
    localparam int PW = 33 + TW;
    localparam logic [PW-1:0] TICKS = PW'(TICKS_PER_SECOND);

    logic [32:0]   mag;
    logic [PW-1:0] prod_reg;
    logic          neg_reg;
    logic          sat_reg;
    logic [31:0]   rem_reg;
    logic [31:0]   quo_reg;
    logic [32:0]   trial;
    logic          ge;

    assign mag   = diff[32] ? 33'(-diff) : 33'(diff);
    assign trial = {rem_reg, quo_reg[31]};
    assign ge    = trial >= {1'b0, dt};

    always_ff @(posedge aclk) begin
        if (ctl.mul) begin
            prod_reg <= PW'(mag) * TICKS;
            neg_reg  <= diff[32];
        end
        if (ctl.pre) begin
            rem_reg <= 32'(prod_reg[PW-1:32]);
            quo_reg <= prod_reg[31:0];
            sat_reg <= 64'(prod_reg[PW-1:32]) >= 64'(dt);
        end else if (ctl.iter) begin
            rem_reg <= ge ? 32'(trial - {1'b0, dt}) : trial[31:0];
            quo_reg <= {quo_reg[30:0], ge};
        end
    end

    // truncating quotient, then clamp to signed 32 bits
    always_comb begin
        if (neg_reg) begin
            if (sat_reg || (quo_reg > 32'h8000_0000)) begin
                rate = 32'h8000_0000;
            end else begin
                rate = 32'(-quo_reg);
            end
        end else begin
            if (sat_reg || quo_reg[31]) begin
                rate = 32'h7FFF_FFFF;
            end else begin
                rate = quo_reg;
            end
        end
    end

endmodule

@@ rtl/finite_difference_velocity_estimator.sv @@
// Finite-difference velocity estimator. A request with tuser 0 only seeds the stored time,
// angle and position; a request with tuser 1 always returns a position result echoing its
// fields and, when the elapsed time is nonzero and below max_gap_us, a velocity result at the
// interval midpoint holding (difference * TICKS_PER_SECOND / elapsed), truncated toward zero
// and saturated to 32 bits. One request is handled at a time by a small microcoded sequencer:
// a measure with velocity runs two 32-step restoring divisions on one shared divider, first
// for the angle rate, then for the position rate. The sequencer waits while m_tready holds a result.
module finite_difference_velocity_estimator
    import fdve_pkg::*;
#(
    parameter int TICKS_PER_SECOND = 1000000
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [31:0] cfg_wr_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [79:0] s_tdata,   // timestamp_us[31:0], angle[47:32], position[79:48]
    input  logic        s_tuser,   // kind
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [95:0] m_tdata,   // stamp_us[31:0], angle_value[63:32], position_value[95:64]
    output logic        m_tuser,   // result_type
    output logic        m_tlast
);

    ucode_t      ctl;
    seq_status_t st;
    logic        accept;

    logic [31:0] max_gap_reg;
    logic        in_kind_reg;
    logic [31:0] in_ts_reg;
    logic [15:0] in_ang_reg;
    logic [31:0] in_pos_reg;
    logic [31:0] prev_time_reg;
    logic [15:0] prev_ang_reg;
    logic [31:0] prev_pos_reg;

    logic [31:0]        dt_reg, mid_reg;
    logic [15:0]        dang_reg;
    logic signed [32:0] dpos_reg;
    logic               vel_reg;
    logic [31:0]        ang_rate_reg;

    logic [31:0]        dt_next;
    logic signed [32:0] div_diff;
    logic [31:0]        rate;

    logic        out_valid_reg;
    logic        out_type_reg, out_last_reg;
    logic [31:0] out_stamp_reg, out_ang_reg, out_pos_reg;
    logic        out_busy, out_load;

    assign s_tready = ctl.take;
    assign accept   = s_tvalid && s_tready;
    assign out_busy = out_valid_reg && !m_tready;
    assign out_load = (ctl.emit_pos || ctl.emit_vel) && !out_busy;

    assign st.accept   = accept;
    assign st.init     = (in_kind_reg == KIND_INIT);
    assign st.out_busy = out_busy;
    assign st.no_vel   = !vel_reg;

    fdve_seq u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .st      (st),
        .ctl     (ctl)
    );

    assign div_diff = ctl.sel_pos ? dpos_reg : 33'(signed'(dang_reg));

    fdve_div #(
        .TICKS_PER_SECOND (TICKS_PER_SECOND)
    ) u_div (
        .aclk (aclk),
        .ctl  (ctl),
        .diff (div_diff),
        .dt   (dt_reg),
        .rate (rate)
    );

    assign dt_next = in_ts_reg - prev_time_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_gap_reg   <= MAX_GAP_RESET;
            prev_time_reg <= '0;
            prev_ang_reg  <= '0;
            prev_pos_reg  <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                max_gap_reg <= cfg_wr_data;
            end
            if (ctl.calc) begin
                prev_time_reg <= in_ts_reg;
                prev_ang_reg  <= in_ang_reg;
                prev_pos_reg  <= in_pos_reg;
            end
            if (out_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            in_kind_reg <= s_tuser;
            in_ts_reg   <= s_tdata[31:0];
            in_ang_reg  <= s_tdata[47:32];
            in_pos_reg  <= s_tdata[79:48];
        end
        if (ctl.calc) begin
            dt_reg   <= dt_next;
            mid_reg  <= prev_time_reg + {1'b0, dt_next[31:1]};
            dang_reg <= in_ang_reg - prev_ang_reg;
            dpos_reg <= 33'(signed'(in_pos_reg)) - 33'(signed'(prev_pos_reg));
            vel_reg  <= (dt_next != '0) && (dt_next < max_gap_reg);
        end
        if (ctl.save_ang) begin
            ang_rate_reg <= rate;
        end
        if (out_load) begin
            if (ctl.emit_vel) begin
                out_type_reg  <= RTYPE_VEL;
                out_stamp_reg <= mid_reg;
                out_ang_reg   <= ang_rate_reg;
                out_pos_reg   <= rate;
                out_last_reg  <= 1'b1;
            end else begin
                out_type_reg  <= RTYPE_POS;
                out_stamp_reg <= in_ts_reg;
                out_ang_reg   <= 32'(signed'(in_ang_reg));
                out_pos_reg   <= in_pos_reg;
                out_last_reg  <= !vel_reg;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_pos_reg, out_ang_reg, out_stamp_reg};
    assign m_tuser  = out_type_reg;
    assign m_tlast  = out_last_reg;

endmodule
